// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the rotate and smooth block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked after reset has been released.
`define ROK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rotate and smooth block assertion failed");
// Checked at every clock edge, reset included.
`define ROK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rotate and smooth block assertion failed");
`else
`define ROK_ASSERT(lbl, clk, rst_n, prop)
`define ROK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rok_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the rotate and smooth block.
package rok_pkg;

  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 16;
  localparam int NOISE_W   = 24;
  localparam int COV_W     = 32;
  localparam int GAIN_W    = 17;
  localparam int DX_W      = 33;
  localparam int CFG_ADDR_W = 4;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(65536);

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = NOISE_W'(655);
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = NOISE_W'(6554);
  localparam logic [COV_W-1:0]   INITIAL_ERROR_RST     = COV_W'(6554);
  localparam logic signed [COEF_W-1:0] COS_HEADING_RST = COEF_W'(32767);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROCESS_NOISE     = 4'd0,
    REG_MEASUREMENT_NOISE = 4'd1,
    REG_INITIAL_ERROR     = 4'd2,
    REG_FILTER_ENABLE     = 4'd3,
    REG_COS_HEADING       = 4'd4,
    REG_SIN_HEADING       = 4'd5,
    REG_ORIGIN_X          = 4'd6,
    REG_ORIGIN_Y          = 4'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_SUM,
    ST_PRED,
    ST_DSTART,
    ST_DIV,
    ST_KMUL,
    ST_KUPD,
    ST_OUT
  } rok_state_e;

  typedef struct packed {
    logic rot_mul;
    logic rot_sum;
    logic kal_mul;
    logic kal_upd;
  } lane_ctrl_t;

endpackage

// ===== rtl/rok_gain_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that forms the Q1.16 Kalman gain, one quotient bit per cycle.
module rok_gain_div
  import rok_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [COV_W-1:0]    pp_i,
  input  logic [NOISE_W-1:0]  mnoise_i,
  output logic                done_o,
  output logic [GAIN_W-1:0]   gain_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [COV_W:0]       den_q;
  logic [COV_W:0]       rem_q;
  logic [GAIN_W-1:0]    quo_q;
  logic                 zero_q;
  logic                 pp_lsb_q;

  logic [COV_W+1:0]     shifted;
  logic [COV_W+2:0]     trial;
  logic                 fits;

  // The dividend is pp * 2^16; its only nonzero bit below bit 17 is pp[0].
  assign shifted = {rem_q, (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) ? pp_lsb_q : 1'b0};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = ~trial[COV_W+2];
  assign done_o  = busy_q && (cnt_q == '0);
  assign gain_o  = zero_q ? '0 : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      busy_q <= (cnt_q != '0);
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q    <= {1'b0, pp_i} + (COV_W+1)'(mnoise_i);
      zero_q   <= (pp_i == '0) && (mnoise_i == '0);
      rem_q    <= (COV_W+1)'(pp_i[COV_W-1:1]);
      pp_lsb_q <= pp_i[0];
      quo_q    <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? trial[COV_W:0] : shifted[COV_W:0];
      quo_q <= {quo_q[GAIN_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/rok_lane.sv =====
`timescale 1ns / 1ps
// One axis lane: rotation by the heading and the scalar Kalman estimate update.
module rok_lane
  import rok_pkg::*;
#(
  parameter int PW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic signed [DX_W-1:0]   dx_i,
  input  logic signed [DX_W-1:0]   dy_i,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic                     sub_i,
  input  logic [GAIN_W-1:0]        gain_i,
  output logic signed [PW-1:0]     raw_o,
  output logic signed [PW-1:0]     est_o
);

  localparam int PROD_W = COEF_W + DX_W;
  localparam int KP_W   = PW + 1 + GAIN_W + 1;
  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (PW - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;

  logic signed [PROD_W-1:0]  prod_a_q, prod_b_q;
  logic signed [PROD_W:0]    rot_sum;
  logic signed [PROD_W-15:0] rot_shr;
  logic signed [PW-1:0]      raw_q, est_q;
  logic signed [PW:0]        diff;
  logic signed [KP_W-1:0]    kprod_q;
  logic signed [PW+2:0]      corr;
  logic signed [PW+3:0]      upd;

  function automatic logic signed [PW-1:0] sat_pw(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX;
    end else if (v < POS_MIN) begin
      r = POS_MIN;
    end else begin
      r = v;
    end
    return r[PW-1:0];
  endfunction

  assign rot_sum = sub_i ? ((PROD_W+1)'(prod_a_q) - (PROD_W+1)'(prod_b_q))
                         : ((PROD_W+1)'(prod_a_q) + (PROD_W+1)'(prod_b_q));
  // Arithmetic shift right by 15 is the floor of the Q1.15 scaling.
  assign rot_shr = $signed(rot_sum[PROD_W:15]);

  assign diff = (PW+1)'(raw_q) - (PW+1)'(est_q);
  assign corr = $signed(kprod_q[KP_W-1:16]);
  assign upd  = (PW+4)'(est_q) + (PW+4)'(corr);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rot_mul) begin
      prod_a_q <= coef_a_i * dx_i;
      prod_b_q <= coef_b_i * dy_i;
    end
    if (ctrl_i.rot_sum) begin
      raw_q <= sat_pw(64'(rot_shr));
    end
    if (ctrl_i.kal_mul) begin
      kprod_q <= $signed({1'b0, gain_i}) * diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
    end else if (ctrl_i.kal_upd) begin
      est_q <= sat_pw(64'(upd));
    end
  end

  assign raw_o = raw_q;
  assign est_o = est_q;

endmodule

// ===== rtl/rotate_offset_kalman_smoother.sv =====
`timescale 1ns / 1ps
// Top level of the rotate, offset and Kalman smoothing block.
`include "assert_macros.svh"
// Usage: one position sample (pos_x, pos_y, Q16.16) enters per item on a
// valid/ready channel. The origin is subtracted, the y difference negated and
// the pair rotated by the configured heading in two lanes, north and east.
// With filtering on, both lanes apply one shared Kalman gain, which a
// restoring divider forms one bit per cycle, and the covariance is updated.
// Each item gives one result item: filtered (or raw) north and east plus the
// raw rotated values, held in an output register.
// Sequence: the lanes multiply, then sum the rotation; with filtering on, the
// covariance is predicted, the 17-step gain divider runs, the gain is applied
// and the estimates and covariance are updated. In bypass the result goes from
// the rotation sum to the output register.
// Items are taken one at a time. A finished result waits in the output
// register while the receiver stalls; the block then holds its last step
// until the register frees and accepts no new item meanwhile.
// Reset clears the estimates, loads the default covariance and restores all
// configuration registers to their defaults. Configuration is written through
// a plain write port while the block is idle; unknown indexes are ignored.
module rotate_offset_kalman_smoother
  import rok_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [FIELD_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FIELD_W-1:0]    pos_x_i,
  input  logic [FIELD_W-1:0]    pos_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FIELD_W-1:0]    north_out_o,
  output logic [FIELD_W-1:0]    east_out_o,
  output logic [FIELD_W-1:0]    raw_north_o,
  output logic [FIELD_W-1:0]    raw_east_o
);

  localparam int PW = POSITION_WIDTH;

  // Configuration registers. The initial error register only matters at reset,
  // and reset always restores its default, so the covariance reset value is
  // that default and the register needs no storage.
  logic [NOISE_W-1:0]       pnoise_q, mnoise_q;
  logic                     filt_en_q;
  logic signed [COEF_W-1:0] cos_q, sin_q;
  logic [FIELD_W-1:0]       origin_x_q, origin_y_q;

  rok_state_e state_q, state_d;
  lane_ctrl_t lane_ctrl;
  logic       div_start, div_done, out_load, accept;

  logic signed [DX_W-1:0] dx_q, dy_q;
  logic [COV_W-1:0]       cov_q, pp_q;
  logic [COV_W:0]         pp_sum;
  logic [GAIN_W-1:0]      gain;
  logic [GAIN_W+COV_W-1:0] cov_prod_q;

  logic signed [PW-1:0] raw_n, raw_e, est_n, est_e;
  logic signed [63:0]   raw_n64, raw_e64, est_n64, est_e64;

  logic                 out_valid_q;
  logic [FIELD_W-1:0]   north_q, east_q, raw_north_q, raw_east_q;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnoise_q   <= PROCESS_NOISE_RST;
      mnoise_q   <= MEASUREMENT_NOISE_RST;
      filt_en_q  <= 1'b1;
      cos_q      <= COS_HEADING_RST;
      sin_q      <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_PROCESS_NOISE:     pnoise_q   <= cfg_wdata_i[NOISE_W-1:0];
        REG_MEASUREMENT_NOISE: mnoise_q   <= cfg_wdata_i[NOISE_W-1:0];
        REG_INITIAL_ERROR: begin
          // Has no effect; a reset restores the default.
        end
        REG_FILTER_ENABLE:     filt_en_q  <= cfg_wdata_i[0];
        REG_COS_HEADING:       cos_q      <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_SIN_HEADING:       sin_q      <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_ORIGIN_X:          origin_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y:          origin_y_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_ROT;
      ST_ROT:    state_d = ST_SUM;
      ST_SUM:    state_d = filt_en_q ? ST_PRED : ST_OUT;
      ST_PRED:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_KMUL;
      ST_KMUL:   state_d = ST_KUPD;
      ST_KUPD:   state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    lane_ctrl  = '0;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_ROT:    lane_ctrl.rot_mul = 1'b1;
      ST_SUM:    lane_ctrl.rot_sum = 1'b1;
      ST_DSTART: div_start = 1'b1;
      ST_KMUL:   lane_ctrl.kal_mul = 1'b1;
      ST_KUPD:   lane_ctrl.kal_upd = 1'b1;
      ST_OUT:    out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Offsets are formed as the item is taken, at one bit wider to stay exact.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= $signed({pos_x_i[FIELD_W-1], pos_x_i})
            - $signed({origin_x_q[FIELD_W-1], origin_x_q});
      dy_q <= $signed({origin_y_q[FIELD_W-1], origin_y_q})
            - $signed({pos_y_i[FIELD_W-1], pos_y_i});
    end
  end

  // Predicted covariance, saturated to 32 bits.
  assign pp_sum = {1'b0, cov_q} + (COV_W+1)'(pnoise_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PRED) begin
      pp_q <= pp_sum[COV_W] ? '1 : pp_sum[COV_W-1:0];
    end
    if (lane_ctrl.kal_mul) begin
      cov_prod_q <= (GAIN_ONE - gain) * pp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q <= INITIAL_ERROR_RST;
    end else if (lane_ctrl.kal_upd) begin
      cov_q <= cov_prod_q[COV_W+15:16];
    end
  end

  rok_gain_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .pp_i     (pp_q),
    .mnoise_i (mnoise_q),
    .done_o   (div_done),
    .gain_o   (gain)
  );

  // North lane: cos*dx - sin*dy. East lane: sin*dx + cos*dy.
  rok_lane #(.PW(PW)) u_lane_n (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .coef_a_i (cos_q),
    .coef_b_i (sin_q),
    .sub_i    (1'b1),
    .gain_i   (gain),
    .raw_o    (raw_n),
    .est_o    (est_n)
  );

  rok_lane #(.PW(PW)) u_lane_e (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .coef_a_i (sin_q),
    .coef_b_i (cos_q),
    .sub_i    (1'b0),
    .gain_i   (gain),
    .raw_o    (raw_e),
    .est_o    (est_e)
  );

  // Merge stage: lane values are sign-extended and cut to the 32-bit fields.
  assign raw_n64 = 64'(raw_n);
  assign raw_e64 = 64'(raw_e);
  assign est_n64 = 64'(est_n);
  assign est_e64 = 64'(est_e);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      raw_north_q <= raw_n64[FIELD_W-1:0];
      raw_east_q  <= raw_e64[FIELD_W-1:0];
      north_q     <= filt_en_q ? est_n64[FIELD_W-1:0] : raw_n64[FIELD_W-1:0];
      east_q      <= filt_en_q ? est_e64[FIELD_W-1:0] : raw_e64[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign north_out_o = north_q;
  assign east_out_o  = east_q;
  assign raw_north_o = raw_north_q;
  assign raw_east_o  = raw_east_q;

  // The divider finishes only while the sequencer waits for it.
  `ROK_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_done |-> (state_q == ST_DIV))
  // The gain is applied only right after the divider has finished.
  `ROK_ASSERT(a_kmul_after_div, clk_i, rst_ni, (state_q == ST_KMUL) |-> $past(div_done))
  // A result waiting on a stalled receiver is never overwritten.
  `ROK_ASSERT(a_out_no_overwrite, clk_i, rst_ni, (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
  // While reset is held the sequencer is idle and no result is shown.
  `ROK_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (state_q == ST_IDLE && !out_valid_q))

endmodule

// ===== dv/tb_rotate_offset_kalman_smoother.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the rotate, offset and Kalman smoothing block.
module tb_rotate_offset_kalman_smoother;
  import rok_pkg::*;

  // Run shape. Each random phase draws a fresh register setting, takes the next
  // idling pattern in turn, then streams position samples through the block.
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_SAMPLES = 225;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WALK_STEP     = 4096;

  localparam longint POS_MAX    = 64'sd2147483647;
  localparam longint POS_MIN    = -64'sd2147483648;
  localparam longint PP_MAX     = 64'sh0000_0000_FFFF_FFFF;
  localparam longint GAIN_UNITY = 64'sd65536;

  // Register indexes that decode to nothing. Writes there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = CFG_ADDR_W'(8);
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = CFG_ADDR_W'(15);
  localparam logic [CFG_ADDR_W-1:0] ADDR_NONE       = '0;

  // One position fix, as the block reports it.
  typedef struct packed {
    logic [FIELD_W-1:0] north_out;
    logic [FIELD_W-1:0] east_out;
    logic [FIELD_W-1:0] raw_north;
    logic [FIELD_W-1:0] raw_east;
  } fix_t;

  localparam fix_t NO_FIX = '0;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  // A directed row is either a register write (addr, word_a) or a sample
  // (word_a = pos_x, word_b = pos_y). A sample may carry a fix typed in by
  // hand; the other samples are checked against the predictor.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [FIELD_W-1:0]    word_a;
    logic [FIELD_W-1:0]    word_b;
    logic                  typed;
    fix_t                  fix;
  } row_t;

  localparam int NUM_DIRECTED = 35;
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    // Straight after reset a sample at the origin gives zero everywhere.
    '{ROW_SAMPLE, ADDR_NONE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    '{ROW_SAMPLE, ADDR_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_FIX},
    // Bypass, written with junk above bit 0, and a heading of exactly -1.0.
    '{ROW_CFG, REG_FILTER_ENABLE, 32'hFFFF_FFFE, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_COS_HEADING,   32'hABCD_8000, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_SIN_HEADING,   32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      '{32'h8000_0001, 32'h0000_0000, 32'h8000_0001, 32'h0000_0000}},
    // Negating the most negative x overflows north; east reaches the floor.
    '{ROW_SAMPLE, ADDR_NONE, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}},
    // Origin at the opposite corners: both differences span 33 bits.
    '{ROW_CFG, REG_ORIGIN_X, 32'h8000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_ORIGIN_Y, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}},
    '{ROW_SAMPLE, ADDR_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
    // A quarter turn, origin back at zero.
    '{ROW_CFG, REG_COS_HEADING, 32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_SIN_HEADING, 32'h0000_7FFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_ORIGIN_X,    32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_ORIGIN_Y,    32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h0001_0000, 32'h0003_0000, 1'b0, NO_FIX},
    // Filter back on with no measurement noise: the gain is exactly one,
    // the estimates jump onto the raw values and the covariance drops to 0.
    '{ROW_CFG, REG_FILTER_ENABLE,     32'h0000_0001, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_MEASUREMENT_NOISE, 32'hFF00_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h0010_0000, 32'hFFF0_0000, 1'b0, NO_FIX},
    // No process noise either: the gain denominator is zero, estimates hold.
    '{ROW_CFG, REG_PROCESS_NOISE, 32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_FIX},
    // A write to the initial covariance has no effect; junk indexes vanish.
    '{ROW_CFG, REG_INITIAL_ERROR, 32'hFFFF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_UNMAPPED_LO,   32'hFFFF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_UNMAPPED_HI,   32'hFFFF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, NO_FIX},
    // Both noises at their maximum, cosine near 0.707 and sine still near one.
    '{ROW_CFG, REG_PROCESS_NOISE,     32'h00FF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_MEASUREMENT_NOISE, 32'h00FF_FFFF, 32'h0, 1'b0, NO_FIX},
    '{ROW_CFG, REG_COS_HEADING,       32'h0000_5A82, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h0005_8000, 32'hFFFD_0000, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_FIX},
    // Zero measurement noise again, now with a large covariance.
    '{ROW_CFG, REG_MEASUREMENT_NOISE, 32'h0000_0000, 32'h0, 1'b0, NO_FIX},
    '{ROW_SAMPLE, ADDR_NONE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NO_FIX}
  };

  // Block ports.
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [FIELD_W-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [FIELD_W-1:0]    pos_x_i;
  logic [FIELD_W-1:0]    pos_y_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [FIELD_W-1:0]    north_out_o;
  logic [FIELD_W-1:0]    east_out_o;
  logic [FIELD_W-1:0]    raw_north_o;
  logic [FIELD_W-1:0]    raw_east_o;

  // Predictor copy of the registers, loaded with their reset values.
  logic [NOISE_W-1:0]       noise_proc = PROCESS_NOISE_RST;
  logic [NOISE_W-1:0]       noise_meas = MEASUREMENT_NOISE_RST;
  logic [NOISE_W-1:0]       err_init   = NOISE_W'(INITIAL_ERROR_RST);
  logic                     filt_on    = 1'b1;
  logic signed [COEF_W-1:0] cos_h      = COS_HEADING_RST;
  logic signed [COEF_W-1:0] sin_h      = '0;
  logic signed [31:0]       org_x      = '0;
  logic signed [31:0]       org_y      = '0;

  // Predictor copy of the filter state.
  logic signed [31:0] north_est = '0;
  logic signed [31:0] east_est  = '0;
  logic [COV_W-1:0]   cov       = INITIAL_ERROR_RST;

  // Fixes predicted for accepted samples, oldest first.
  fix_t fix_q[$];
  fix_t model_fix;

  // A hand-typed fix travels with its sample so the monitor can use it.
  logic typed_on;
  fix_t typed_fix;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int samples_taken   = 0;
  int fixes_checked   = 0;
  int mismatches      = 0;
  int settings_run    = 0;

  rotate_offset_kalman_smoother DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .north_out_o (north_out_o),
    .east_out_o  (east_out_o),
    .raw_north_o (raw_north_o),
    .raw_east_o  (raw_east_o)
  );

  always #1 clk_i = ~clk_i;

  // Clamp a wide intermediate to a signed Q16.16 position.
  function automatic logic signed [31:0] sat_q16(input longint v);
    if (v > POS_MAX) return 32'(POS_MAX);
    if (v < POS_MIN) return 32'(POS_MIN);
    return 32'(v);
  endfunction

  // Move one estimate toward its measurement by a Q1.16 gain. The product is
  // floored, which matches taking the upper bits of the full product in the lane.
  function automatic logic signed [31:0] smooth_axis(input logic signed [31:0] est,
                                                     input logic signed [31:0] meas,
                                                     input longint gain);
    longint e;
    longint d;
    e = est;
    d = longint'(meas) - e;
    return sat_q16(e + ((gain * d) >>> 16));
  endfunction

  // Rotate one sample into north and east and, with the filter on, advance
  // both estimates and the shared covariance.
  function automatic fix_t predict_fix(input logic [FIELD_W-1:0] x,
                                       input logic [FIELD_W-1:0] y);
    longint dx;
    longint dy;
    longint pp;
    longint den;
    longint gain;
    logic signed [31:0] rn;
    logic signed [31:0] re;
    fix_t f;
    dx = longint'($signed(x)) - longint'(org_x);
    dy = longint'(org_y) - longint'($signed(y));
    rn = sat_q16((cos_h * dx - sin_h * dy) >>> 15);
    re = sat_q16((sin_h * dx + cos_h * dy) >>> 15);
    f.raw_north = rn;
    f.raw_east  = re;
    f.north_out = rn;
    f.east_out  = re;
    if (filt_on) begin
      pp = longint'(cov) + longint'(noise_proc);
      if (pp > PP_MAX) pp = PP_MAX;
      den = pp + longint'(noise_meas);
      // A zero denominator leaves the gain at zero, so nothing moves.
      gain = (den == 0) ? 0 : (pp <<< 16) / den;
      north_est = smooth_axis(north_est, rn, gain);
      east_est  = smooth_axis(east_est, re, gain);
      cov = 32'(((GAIN_UNITY - gain) * pp) >>> 16);
      f.north_out = north_est;
      f.east_out  = east_est;
    end
    return f;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_fix();
    fix_t want;
    if (fix_q.size() == 0) begin
      $error("position fix with no sample pending: north_out %h", north_out_o);
      mismatches++;
    end else begin
      want = fix_q.pop_front();
      compare_field("north_out", want.north_out, north_out_o);
      compare_field("east_out", want.east_out, east_out_o);
      compare_field("raw_north", want.raw_north, raw_north_o);
      compare_field("raw_east", want.raw_east, raw_east_o);
      fixes_checked++;
    end
  endtask

  // Both handshakes are sampled at the clock edge, before any of this edge's
  // nonblocking updates land. The output side is checked first, so a fix can
  // never be matched against a sample taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_fix();
      if (in_valid_i && in_ready_o) begin
        // The predictor always runs so its state keeps step with the block.
        model_fix = predict_fix(pos_x_i, pos_y_i);
        fix_q.insert(fix_q.size(), typed_on ? typed_fix : model_fix);
        samples_taken++;
      end
    end
  end

  // Receiver. A long hold requested by the stimulus is counted down here;
  // otherwise ready drops at random at the current stall rate.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_ready_i <= 1'b0;
        hold_req--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Registers change only while the block is idle, so the predictor copy is
  // updated as soon as the write is driven.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      REG_PROCESS_NOISE:     noise_proc = data[NOISE_W-1:0];
      REG_MEASUREMENT_NOISE: noise_meas = data[NOISE_W-1:0];
      REG_INITIAL_ERROR:     err_init   = data[NOISE_W-1:0];
      REG_FILTER_ENABLE:     filt_on    = data[0];
      REG_COS_HEADING:       cos_h      = data[COEF_W-1:0];
      REG_SIN_HEADING:       sin_h      = data[COEF_W-1:0];
      REG_ORIGIN_X:          org_x      = data;
      REG_ORIGIN_Y:          org_y      = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted fix has come back. Every
  // sample yields a fix, so an empty queue means the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fix_q.size() != 0) @(posedge clk_i);
  endtask

  // Offer one sample after a random idle gap and hold it until accepted.
  // Valid is raised only once per step, so back-to-back samples keep it high.
  task automatic offer_sample(input logic [31:0] x, input logic [31:0] y,
                              input logic typed, input fix_t fix);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    typed_on   <= typed;
    typed_fix  <= fix;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Noise values lean toward zero, full scale and small practical values.
  // The top byte carries junk that the block must drop.
  function automatic logic [31:0] pick_noise();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0:       v[NOISE_W-1:0] = '0;
      1:       v[NOISE_W-1:0] = '1;
      2, 3:    v[NOISE_W-1:0] = NOISE_W'($urandom_range(4096));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_heading();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0:       v[COEF_W-1:0] = 16'h7FFF;
      1:       v[COEF_W-1:0] = 16'h8000;
      2:       v[COEF_W-1:0] = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic randomize_regs();
    logic [31:0] en;
    en    = $urandom;
    en[0] = ($urandom_range(3) != 0);
    write_reg(REG_PROCESS_NOISE, pick_noise());
    write_reg(REG_MEASUREMENT_NOISE, pick_noise());
    write_reg(REG_INITIAL_ERROR, pick_noise());
    write_reg(REG_FILTER_ENABLE, en);
    write_reg(REG_COS_HEADING, pick_heading());
    write_reg(REG_SIN_HEADING, pick_heading());
    write_reg(REG_ORIGIN_X, pick_origin());
    write_reg(REG_ORIGIN_Y, pick_origin());
    if ($urandom_range(2) == 0)
      write_reg(CFG_ADDR_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)), $urandom);
    settings_run++;
  endtask

  initial begin
    logic [31:0] walk_x;
    logic [31:0] walk_y;
    logic [31:0] sx;
    logic [31:0] sy;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    typed_on    = 1'b0;
    typed_fix   = NO_FIX;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, bypass, each filter corner case and the
    // register writes that must have no visible effect.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        if (i > 0 && DIRECTED[i-1].kind == ROW_SAMPLE) settle();
        write_reg(DIRECTED[i].addr, DIRECTED[i].word_a);
      end else begin
        offer_sample(DIRECTED[i].word_a, DIRECTED[i].word_b, DIRECTED[i].typed,
                     DIRECTED[i].fix);
      end
    end

    // Random phases. Idling cycles through none, sender only, receiver only
    // and both. Most samples follow a slow walk around the origin so the
    // filter has something to converge on; the rest are anywhere at all.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      randomize_regs();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      walk_x = org_x;
      walk_y = org_y;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // The receiver goes quiet for a long stretch while samples keep
        // coming, so the output register fills and the input backs up.
        if (phase % 4 == 0 && n == PHASE_SAMPLES / 4) hold_req = LONG_HOLD;
        // Halfway through, the sender waits for every fix to come home.
        if (n == PHASE_SAMPLES / 2) settle();
        walk_x = walk_x + 32'($urandom_range(2 * WALK_STEP)) - 32'(WALK_STEP);
        walk_y = walk_y + 32'($urandom_range(2 * WALK_STEP)) - 32'(WALK_STEP);
        if ($urandom_range(4) == 0) begin
          sx = $urandom;
          sy = $urandom;
        end else begin
          sx = walk_x + 32'($urandom_range(1023)) - 32'd512;
          sy = walk_y + 32'($urandom_range(1023)) - 32'd512;
        end
        offer_sample(sx, sy, 1'b0, NO_FIX);
      end
    end

    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (fix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d samples, %0d fixes checked, %0d random register settings",
             samples_taken, fixes_checked, settings_run);
    $display("summary: %0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== rotate_offset_kalman_smoother.f =====
+incdir+rtl
rtl/rok_pkg.sv
rtl/rok_gain_div.sv
rtl/rok_lane.sv
rtl/rotate_offset_kalman_smoother.sv
dv/tb_rotate_offset_kalman_smoother.sv
